[rtl/gdn_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and the month table for the gregorian day number block
// no dependencies

package gdn_pkg;

    localparam int YEAR_BITS_DEF = 16;

    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DAYS_W   = 25;
    localparam int WDAY_W   = 3;
    localparam int SECS_W   = 41;
    localparam int TOD_W    = 17;
    localparam int DOY_W    = 9;
    localparam int REST_W   = 7;

    localparam int MONTH_FIRST    = 1;
    localparam int MONTH_LAST     = 12;
    localparam int MONTH_FEB      = 2;
    localparam int HOUR_MAX       = 23;
    localparam int MINUTE_MAX     = 59;
    localparam int SECOND_MAX     = 59;
    localparam int YEARS_PER_CENT = 100;
    localparam int DAYS_PER_CENT  = 36524;
    localparam int DAYS_PER_YEAR  = 365;
    localparam int WEEK_DAYS      = 7;
    localparam int SECS_PER_MIN   = 60;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_DAY   = 3600 * 24;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour_of_day;
        logic [MINUTE_W-1:0] minute_of_hour;
        logic [SECOND_W-1:0] second_of_minute;
        logic                pair_second;
    } date_in_t;

    typedef struct packed {
        logic              status;
        logic [DAYS_W-1:0] days_since_epoch;
        logic [WDAY_W-1:0] weekday;
        logic [SECS_W-1:0] seconds_since_epoch;
        logic              diff_valid;
        logic [DAYS_W-1:0] diff_days;
        logic [SECS_W-1:0] diff_seconds;
    } day_result_t;

    // one converted date on its way to the pair store
    typedef struct packed {
        logic              ok;
        logic              pair;
        logic [DAYS_W-1:0] days;
        logic [WDAY_W-1:0] weekday;
        logic [SECS_W-1:0] secs;
    } stamp_t;

    // days before the first of the month, month 1..12
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] r;
        case (month)
            4'd1:    r = DOY_W'(0);
            4'd2:    r = DOY_W'(31);
            4'd3:    r = DOY_W'(59);
            4'd4:    r = DOY_W'(90);
            4'd5:    r = DOY_W'(120);
            4'd6:    r = DOY_W'(151);
            4'd7:    r = DOY_W'(181);
            4'd8:    r = DOY_W'(212);
            4'd9:    r = DOY_W'(243);
            4'd10:   r = DOY_W'(273);
            4'd11:   r = DOY_W'(304);
            4'd12:   r = DOY_W'(334);
            default: r = DOY_W'(0);
        endcase
        return r;
    endfunction

endpackage

[rtl/gdn_stream_if.sv]
`timescale 1ns / 1ps
// valid/ready stream channel carrying one payload per transaction
// payload type is set per instance, no package dependency

interface gdn_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/gdn_date_pipe.sv]
`timescale 1ns / 1ps
// input register and four-stage date to day and second count pipeline
// depends on gdn_pkg

module gdn_date_pipe
    import gdn_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     date_valid,
    output logic     date_ready,
    input  date_in_t date,
    output logic     stamp_valid,
    input  logic     stamp_ready,
    output stamp_t   stamp
);

    localparam int CENT_W     = YEAR_BITS - 6;
    localparam int DAYF_W     = YEAR_BITS + 9;
    localparam int DIV_SH     = YEAR_BITS + 7;
    localparam int PROD_W     = 2 * YEAR_BITS + 1;
    localparam int DIV100_INT = ((1 << DIV_SH) + YEARS_PER_CENT - 1) / YEARS_PER_CENT;
    localparam logic [YEAR_BITS:0] DIV100_M = DIV100_INT[YEAR_BITS:0];
    localparam int STAGES     = 5;
    localparam int DIGITS     = (DAYS_W + 2) / 3;
    localparam int DSUM_W     = 6;

    typedef logic [YEAR_BITS-1:0] year_t;
    typedef logic [CENT_W-1:0]    cent_t;

    typedef struct packed {
        logic             ok;
        logic             pair;
        year_t            ym1;
        cent_t            cent;
        logic [TOD_W-1:0] tod;
        logic [DOY_W-1:0] doy0;
        logic             after_feb;
        logic             div4;
    } stb_t;

    typedef struct packed {
        logic              ok;
        logic              pair;
        cent_t             cent;
        logic [REST_W-1:0] rest;
        logic [DOY_W-1:0]  doy;
        logic [TOD_W-1:0]  tod;
    } stc_t;

    typedef struct packed {
        logic              ok;
        logic              pair;
        logic [DAYF_W-1:0] days_full;
        logic [TOD_W-1:0]  tod;
    } std_t;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   adv;

    date_in_t a_reg;
    stb_t     b_reg, b_next;
    stc_t     c_reg, c_next;
    std_t     d_reg, d_next;
    stamp_t   e_reg, e_next;

    year_t              yr;
    logic [PROD_W-1:0]  prod;
    year_t              rest_full;
    logic               leap;
    logic [3*DIGITS-1:0] days_pad;
    logic [DSUM_W-1:0]  dsum;
    logic [3:0]         fold1;
    logic [3:0]         fold2;
    logic [3:0]         fold3;

    always_comb
    begin
        adv[STAGES] = stamp_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign date_ready  = adv[0];
    assign stamp_valid = vld_reg[STAGES-1];
    assign stamp       = e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= date_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // range check, year split by reciprocal of 100, time of day, day of year
    always_comb
    begin
        yr   = YEAR_BITS'(a_reg.year);
        prod = PROD_W'(yr - YEAR_BITS'(1)) * PROD_W'(DIV100_M);

        b_next.ok = (yr != '0)
                 && (a_reg.month >= MONTH_W'(MONTH_FIRST))
                 && (a_reg.month <= MONTH_W'(MONTH_LAST))
                 && (a_reg.day != '0)
                 && (a_reg.hour_of_day <= HOUR_W'(HOUR_MAX))
                 && (a_reg.minute_of_hour <= MINUTE_W'(MINUTE_MAX))
                 && (a_reg.second_of_minute <= SECOND_W'(SECOND_MAX));
        b_next.pair      = a_reg.pair_second;
        b_next.ym1       = yr - YEAR_BITS'(1);
        b_next.cent      = prod[DIV_SH +: CENT_W];
        b_next.tod       = TOD_W'(a_reg.hour_of_day) * TOD_W'(SECS_PER_HOUR)
                         + TOD_W'(a_reg.minute_of_hour) * TOD_W'(SECS_PER_MIN)
                         + TOD_W'(a_reg.second_of_minute);
        b_next.doy0      = month_start(a_reg.month) + DOY_W'(a_reg.day) - DOY_W'(1);
        b_next.after_feb = a_reg.month > MONTH_W'(MONTH_FEB);
        b_next.div4      = yr[1:0] == 2'b00;
    end

    // years left in the century and leap day
    always_comb
    begin
        rest_full = b_reg.ym1 - YEAR_BITS'(b_reg.cent) * YEAR_BITS'(YEARS_PER_CENT);
        c_next.rest = REST_W'(rest_full);
        leap = b_reg.div4
            && ((c_next.rest != REST_W'(YEARS_PER_CENT - 1)) || (b_reg.cent[1:0] == 2'b11));
        c_next.ok   = b_reg.ok;
        c_next.pair = b_reg.pair;
        c_next.cent = b_reg.cent;
        c_next.doy  = b_reg.doy0 + DOY_W'(b_reg.after_feb && leap);
        c_next.tod  = b_reg.tod;
    end

    // full day count
    always_comb
    begin
        d_next.ok        = c_reg.ok;
        d_next.pair      = c_reg.pair;
        d_next.tod       = c_reg.tod;
        d_next.days_full = DAYF_W'(c_reg.cent) * DAYF_W'(DAYS_PER_CENT)
                         + DAYF_W'(c_reg.cent >> 2)
                         + DAYF_W'(c_reg.rest) * DAYF_W'(DAYS_PER_YEAR)
                         + DAYF_W'(c_reg.rest >> 2)
                         + DAYF_W'(c_reg.doy);
    end

    // seconds and weekday, octal digit sum since 8 is 1 mod 7
    always_comb
    begin
        e_next.ok   = d_reg.ok;
        e_next.pair = d_reg.pair;
        e_next.days = DAYS_W'(d_reg.days_full);
        e_next.secs = SECS_W'(d_reg.days_full) * SECS_W'(SECS_PER_DAY) + SECS_W'(d_reg.tod);
        days_pad    = (3 * DIGITS)'(e_next.days);
        dsum        = '0;
        for (int k = 0; k < DIGITS; k++)
        begin
            dsum = dsum + DSUM_W'(days_pad[3*k +: 3]);
        end
        fold1 = {1'b0, dsum[5:3]} + {1'b0, dsum[2:0]};
        fold2 = (fold1 >= 4'(WEEK_DAYS)) ? fold1 - 4'(WEEK_DAYS) : fold1;
        fold3 = (fold2 >= 4'(WEEK_DAYS)) ? fold2 - 4'(WEEK_DAYS) : fold2;
        e_next.weekday = WDAY_W'(fold3);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_reg <= date;
        end
        if (adv[1])
        begin
            b_reg <= b_next;
        end
        if (adv[2])
        begin
            c_reg <= c_next;
        end
        if (adv[3])
        begin
            d_reg <= d_next;
        end
        if (adv[4])
        begin
            e_reg <= e_next;
        end
    end

endmodule

[rtl/gdn_pair_diff.sv]
`timescale 1ns / 1ps
// first-date store, pair differences and the result register
// depends on gdn_pkg

module gdn_pair_diff
    import gdn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stamp_valid,
    output logic        stamp_ready,
    input  stamp_t      stamp,
    output logic        res_valid,
    input  logic        res_ready,
    output day_result_t res
);

    logic              first_valid_reg, first_valid_next;
    logic [DAYS_W-1:0] first_days_reg, first_days_next;
    logic [SECS_W-1:0] first_secs_reg, first_secs_next;
    logic              out_vld_reg;
    day_result_t       out_reg, out_next;
    logic              take;

    assign stamp_ready = !out_vld_reg || res_ready;
    assign take        = stamp_valid && stamp_ready;
    assign res_valid   = out_vld_reg;
    assign res         = out_reg;

    always_comb
    begin
        out_next         = '0;
        first_valid_next = first_valid_reg;
        first_days_next  = first_days_reg;
        first_secs_next  = first_secs_reg;
        if (!stamp.ok)
        begin
            out_next.status  = STATUS_BAD;
            first_valid_next = 1'b0;
        end
        else
        begin
            out_next.status              = STATUS_OK;
            out_next.days_since_epoch    = stamp.days;
            out_next.weekday             = stamp.weekday;
            out_next.seconds_since_epoch = stamp.secs;
            if (!stamp.pair)
            begin
                first_valid_next = 1'b1;
                first_days_next  = stamp.days;
                first_secs_next  = stamp.secs;
            end
            else
            begin
                if (first_valid_reg)
                begin
                    out_next.diff_valid   = 1'b1;
                    out_next.diff_days    = (stamp.days >= first_days_reg)
                                          ? stamp.days - first_days_reg
                                          : first_days_reg - stamp.days;
                    out_next.diff_seconds = (stamp.secs >= first_secs_reg)
                                          ? stamp.secs - first_secs_reg
                                          : first_secs_reg - stamp.secs;
                end
                first_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg     <= 1'b0;
            first_valid_reg <= 1'b0;
        end
        else
        begin
            if (stamp_ready)
            begin
                out_vld_reg <= stamp_valid;
            end
            if (take)
            begin
                first_valid_reg <= first_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg        <= out_next;
            first_days_reg <= first_days_next;
            first_secs_reg <= first_secs_next;
        end
    end

endmodule

[rtl/gregorian_date_to_day_number.sv]
`timescale 1ns / 1ps
// Converts a proleptic Gregorian date and time of day into the day count and
// second count since 1 January of year 1, plus the weekday (0 is Monday), and
// for the second date of a pair the absolute day and second distance to the
// stored first date. One transaction can be accepted every clock cycle unless
// back pressure has filled the pipeline. A date passes an input register and
// five register stages: year split by a reciprocal multiply, leap and century
// remainder, day count, seconds multiply and weekday, then the pair store
// feeding the result register. Back pressure on the result side stalls only
// the stages that hold data, so bubbles in the pipeline are filled first.
// Depends on gdn_pkg, gdn_stream_if, gdn_date_pipe and gdn_pair_diff.

module gregorian_date_to_day_number
    import gdn_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    gdn_stream_if.sink   dates,
    gdn_stream_if.source results
);

    logic   stamp_valid;
    logic   stamp_ready;
    stamp_t stamp;

    gdn_date_pipe #(
        .YEAR_BITS (YEAR_BITS)
    ) u_date_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .date_valid  (dates.valid),
        .date_ready  (dates.ready),
        .date        (dates.payload),
        .stamp_valid (stamp_valid),
        .stamp_ready (stamp_ready),
        .stamp       (stamp)
    );

    gdn_pair_diff u_pair_diff (
        .clk         (clk),
        .rst_n       (rst_n),
        .stamp_valid (stamp_valid),
        .stamp_ready (stamp_ready),
        .stamp       (stamp),
        .res_valid   (results.valid),
        .res_ready   (results.ready),
        .res         (results.payload)
    );

endmodule

[rtl/gdn_checker.sv]
`timescale 1ns / 1ps
// result-side checks for the gregorian day number block, bound to the top level
// depends on gdn_pkg

module gdn_checker
    import gdn_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input day_result_t res
);

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.status == STATUS_BAD) |->
            (res.days_since_epoch == '0) && (res.seconds_since_epoch == '0)
            && (res.weekday == '0) && !res.diff_valid
            && (res.diff_days == '0) && (res.diff_seconds == '0))
        else $error("invalid date result carries nonzero fields");

    a_diff_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.diff_valid |-> (res.status == STATUS_OK))
        else $error("pair difference on an invalid date");

    a_no_diff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.diff_valid |-> (res.diff_days == '0) && (res.diff_seconds == '0))
        else $error("difference fields set without a pair result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed");

endmodule

bind gregorian_date_to_day_number gdn_checker u_gdn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res       (results.payload)
);
